/* rtl/bgen_l2pd_pkg.sv */
// bgen_l2pd_pkg: shared types and constants of the layout-2 probability decoder
// no dependencies; imported by bgen_layout2_probability_decoder_top
package bgen_l2pd_pkg;

  // status codes, in the order of the status field
  localparam logic [3:0] ST_OK     = 4'd0;
  localparam logic [3:0] ST_TRUNC  = 4'd1;
  localparam logic [3:0] ST_COUNT  = 4'd2;
  localparam logic [3:0] ST_ALLELE = 4'd3;
  localparam logic [3:0] ST_PLOIDY = 4'd4;
  localparam logic [3:0] ST_PHASED = 4'd5;
  localparam logic [3:0] ST_PHFLAG = 4'd6;
  localparam logic [3:0] ST_DEPTH  = 4'd7;
  localparam logic [3:0] ST_WIDE   = 4'd8;
  localparam logic [3:0] ST_SIZE   = 4'd9;
  localparam logic [3:0] ST_SUM    = 4'd10;

  // error flag bit positions (code minus one)
  localparam int E_COUNT  = 1;
  localparam int E_ALLELE = 2;
  localparam int E_PLOIDY = 3;
  localparam int E_PHASED = 4;
  localparam int E_PHFLAG = 5;
  localparam int E_DEPTH  = 6;
  localparam int E_WIDE   = 7;
  localparam int E_SIZE   = 8;
  localparam int E_SUM    = 9;
  localparam int ERR_W    = 10;

  localparam logic [7:0]  PLOIDY_MASK  = 8'h3F;
  localparam int          MISSING_BIT  = 7;
  localparam logic [7:0]  DIPLOID      = 8'd2;
  localparam logic [15:0] ALLELES_OK   = 16'd2;
  localparam int          HEADER_FIXED = 10;
  localparam logic [7:0]  WIDE_LIMIT   = 8'd16;
  localparam logic [7:0]  DEPTH_LIMIT  = 8'd32;
  localparam int          DIV_STEPS    = 18;

  typedef struct packed {
    logic        kind;
    logic [15:0] index;
    logic [15:0] hom;
    logic [15:0] het;
    logic        miss;
    logic [17:0] dosage;
    logic [3:0]  status;
    logic [7:0]  depth;
    logic        last;
  } out_rec_t;

endpackage

/* rtl/bgen_l2pd_ram.sv */
// bgen_l2pd_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module bgen_l2pd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bgen_layout2_probability_decoder_top.sv */
// bgen_layout2_probability_decoder_top: streaming layout-2 probability decoder
// depends on bgen_l2pd_pkg and bgen_l2pd_ram
//
// usage: one variant's uncompressed probability data enters one byte per
// input transaction (in_data_byte, in_last_byte on the final byte). the header
// is checked as it passes, each sample's missing bit goes to an on-chip ram,
// and the packed values are split into pairs. every completed pair whose sum
// stays within the value mask gives one sample result; the final byte gives
// one status result (run_last high), then the variant state clears.
// cfg_sample_count must be written while idle. header bytes are taken while
// idle. a decoded data byte is unpacked value by value; each completed pair
// then passes through the ram read, the check, an 18-step restoring divider
// for the dosage and the output load, and a missing sample skips the divider.
// the final byte adds a product and length check. the divider sets the rate;
// in_stall stays high until a byte is decoded, so no new byte is taken.
// results sit in one output register; while it is full and out_stall is high
// the decoder waits before loading the next result and holds in_stall high meanwhile.
// reset (synchronous, rst_n low) clears the variant state, sets the sample
// count to 1 and empties the output; the missing-flag ram is not cleared.
module bgen_layout2_probability_decoder_top
  import bgen_l2pd_pkg::*;
#(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_sample_count,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [15:0] out_sample_index,
  output logic [15:0] out_prob_hom,
  output logic [15:0] out_prob_het,
  output logic        out_is_missing,
  output logic [17:0] out_dosage_fx,
  output logic [3:0]  out_status_code,
  output logic [7:0]  out_depth_bits,
  output logic        out_run_last
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int PW = CW + 9;
  localparam logic [31:0] MAX_U = 32'(MAX_SAMPLES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UNPK  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_STAT1 = 3'd5;
  localparam logic [2:0] S_STAT2 = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [23:0]      hdr_r, hdr_nxt;
  logic [7:0]       allele_lo_r, allele_lo_nxt;
  logic [7:0]       depth_r, depth_nxt;
  logic [23:0]      acc_r, acc_nxt;
  logic [4:0]       held_r, held_nxt;
  logic [15:0]      first_r, first_nxt;
  logic             first_vld_r, first_vld_nxt;
  logic [CW-1:0]    next_r, next_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic             last_pend_r, last_pend_nxt;
  logic [15:0]      a_r, a_nxt;
  logic [15:0]      v_r, v_nxt;
  logic [16:0]      rem_r, rem_nxt;
  logic [17:0]      sh_r, sh_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [PW-1:0]    prod_r, prod_nxt;
  out_rec_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             accept, out_free, out_load;
  logic [PW-1:0]    n_p, lim, exp_len;
  logic [PW:0]      db_sum;
  logic [PW-1:0]    ploidy_off;
  logic [31:0]      cfg_ext, cfg_sat;
  logic [16:0]      mask17, div_d, sum17;
  logic [15:0]      mask16, val;
  logic [4:0]       dep5;
  logic [17:0]      x_sum;
  logic [34:0]      num;
  logic [17:0]      rem2;
  logic             ge;
  logic [3:0]       status;
  logic             mem_we, mem_re, mem_rdata;
  logic [AW-1:0]    mem_waddr;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign n_p        = PW'(n_r);
  assign lim        = PW'(HEADER_FIXED) + n_p;
  assign ploidy_off = pos_r - PW'(8);
  assign mem_waddr  = ploidy_off[AW-1:0];
  assign mem_we     = accept && (pos_r >= PW'(8)) && (pos_r < PW'(8) + n_p);

  assign cfg_ext = {15'd0, cfg_sample_count};
  assign cfg_sat = (cfg_ext > MAX_U) ? MAX_U : cfg_ext;

  assign dep5   = depth_r[4:0];
  assign mask17 = (17'd1 << dep5) - 17'd1;
  assign mask16 = mask17[15:0];
  assign val    = acc_r[15:0] & mask16;
  assign div_d  = {mask16, 1'b0};
  assign sum17  = {1'b0, a_r} + {1'b0, v_r};
  // numerator of the rounded dosage: 2x * 65536 + mask, x = 2a + v
  assign x_sum  = {1'b0, a_r, 1'b0} + {2'b00, v_r};
  assign num    = {x_sum, 17'd0} + {18'd0, mask17};
  assign rem2   = {rem_r, sh_r[17]};
  assign ge     = (rem2 >= {1'b0, div_d});

  // expected length and status priority
  assign db_sum  = {1'b0, prod_r} + (PW+1)'(7);
  assign exp_len = lim + db_sum[PW:3];

  always_comb begin
    priority if (pos_r < lim)              status = ST_TRUNC;
    else if (err_r[E_COUNT])               status = ST_COUNT;
    else if (err_r[E_ALLELE])              status = ST_ALLELE;
    else if (err_r[E_PHASED])              status = ST_PHASED;
    else if (err_r[E_PHFLAG])              status = ST_PHFLAG;
    else if (err_r[E_DEPTH])               status = ST_DEPTH;
    else if (err_r[E_WIDE])                status = ST_WIDE;
    else if (err_r[E_PLOIDY])              status = ST_PLOIDY;
    else if (pos_r != exp_len)             status = ST_SIZE;
    else if (err_r[E_SUM])                 status = ST_SUM;
    else                                   status = ST_OK;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = cfg_we ? cfg_sat[CW-1:0] : n_r;
    pos_nxt       = pos_r;
    hdr_nxt       = hdr_r;
    allele_lo_nxt = allele_lo_r;
    depth_nxt     = depth_r;
    acc_nxt       = acc_r;
    held_nxt      = held_r;
    first_nxt     = first_r;
    first_vld_nxt = first_vld_r;
    next_nxt      = next_r;
    idx_nxt       = idx_r;
    err_nxt       = err_r;
    last_pend_nxt = last_pend_r;
    a_nxt         = a_r;
    v_nxt         = v_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    out_nxt       = out_r;
    out_load      = 1'b0;
    mem_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (pos_r != '1) begin
            pos_nxt = pos_r + PW'(1);
          end
          priority if (pos_r < PW'(4)) begin
            unique case (pos_r[1:0])
              2'd0: hdr_nxt[7:0]   = in_data_byte;
              2'd1: hdr_nxt[15:8]  = in_data_byte;
              2'd2: hdr_nxt[23:16] = in_data_byte;
              default: begin
                if ({in_data_byte, hdr_r} != 32'(n_r)) begin
                  err_nxt[E_COUNT] = 1'b1;
                end
              end
            endcase
          end else if (pos_r < PW'(6)) begin
            if (pos_r[0] == 1'b0) begin
              allele_lo_nxt = in_data_byte;
            end else if ({in_data_byte, allele_lo_r} != ALLELES_OK) begin
              err_nxt[E_ALLELE] = 1'b1;
            end
          end else if (pos_r < PW'(8)) begin
            // min and max ploidy carry no check
          end else if (pos_r < PW'(8) + n_p) begin
            if ((in_data_byte & PLOIDY_MASK) != DIPLOID) begin
              err_nxt[E_PLOIDY] = 1'b1;
            end
          end else if (pos_r == PW'(8) + n_p) begin
            if (in_data_byte == 8'd1) begin
              err_nxt[E_PHASED] = 1'b1;
            end else if (in_data_byte != 8'd0) begin
              err_nxt[E_PHFLAG] = 1'b1;
            end
          end else if (pos_r == PW'(9) + n_p) begin
            depth_nxt = in_data_byte;
            if (in_data_byte == 8'd0 || in_data_byte > DEPTH_LIMIT) begin
              err_nxt[E_DEPTH] = 1'b1;
            end else if (in_data_byte > WIDE_LIMIT) begin
              err_nxt[E_WIDE] = 1'b1;
            end
          end else if (err_r == '0 && next_r < n_r) begin
            acc_nxt   = acc_r | (24'(in_data_byte) << held_r);
            held_nxt  = held_r + 5'd8;
            state_nxt = S_UNPK;
          end
          if (in_last_byte) begin
            last_pend_nxt = 1'b1;
            if (state_nxt == S_IDLE) begin
              state_nxt = S_STAT1;
            end
          end
        end
      end

      S_UNPK: begin
        if (held_r >= dep5 && next_r < n_r && err_r == '0) begin
          acc_nxt  = acc_r >> dep5;
          held_nxt = held_r - dep5;
          if (!first_vld_r) begin
            first_nxt     = val;
            first_vld_nxt = 1'b1;
          end else begin
            a_nxt         = first_r;
            v_nxt         = val;
            first_nxt     = 16'd0;
            first_vld_nxt = 1'b0;
            idx_nxt       = next_r;
            next_nxt      = next_r + CW'(1);
            mem_re        = 1'b1;
            state_nxt     = S_CHK;
          end
        end else begin
          state_nxt = last_pend_r ? S_STAT1 : S_IDLE;
        end
      end

      S_CHK: begin
        if (mem_rdata) begin
          if (out_free) begin
            out_load  = 1'b1;
            out_nxt   = '{kind: 1'b0, index: 16'(idx_r), hom: 16'd0, het: 16'd0,
                          miss: 1'b1, dosage: 18'd0, status: ST_OK, depth: depth_r,
                          last: 1'b0};
            state_nxt = S_UNPK;
          end
        end else if (sum17 > mask17) begin
          err_nxt[E_SUM] = 1'b1;
          state_nxt      = S_UNPK;
        end else begin
          rem_nxt   = num[34:18];
          sh_nxt    = num[17:0];
          cnt_nxt   = 5'd0;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        rem_nxt = ge ? 17'(rem2 - {1'b0, div_d}) : rem2[16:0];
        sh_nxt  = {sh_r[16:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_nxt   = '{kind: 1'b0, index: 16'(idx_r), hom: a_r, het: v_r,
                        miss: 1'b0, dosage: sh_r, status: ST_OK, depth: depth_r,
                        last: 1'b0};
          state_nxt = S_UNPK;
        end
      end

      S_STAT1: begin
        prod_nxt  = PW'({n_r, 1'b0}) * PW'(depth_r);
        state_nxt = S_STAT2;
      end

      S_STAT2: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_nxt       = '{kind: 1'b1, index: 16'd0, hom: 16'd0, het: 16'd0,
                            miss: 1'b0, dosage: 18'd0, status: status,
                            depth: depth_r, last: 1'b1};
          pos_nxt       = '0;
          hdr_nxt       = '0;
          allele_lo_nxt = '0;
          depth_nxt     = '0;
          acc_nxt       = '0;
          held_nxt      = '0;
          first_nxt     = '0;
          first_vld_nxt = 1'b0;
          next_nxt      = '0;
          err_nxt       = '0;
          last_pend_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= CW'(1);
      pos_r       <= '0;
      hdr_r       <= '0;
      allele_lo_r <= '0;
      depth_r     <= '0;
      acc_r       <= '0;
      held_r      <= '0;
      first_r     <= '0;
      first_vld_r <= 1'b0;
      next_r      <= '0;
      err_r       <= '0;
      last_pend_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      pos_r       <= pos_nxt;
      hdr_r       <= hdr_nxt;
      allele_lo_r <= allele_lo_nxt;
      depth_r     <= depth_nxt;
      acc_r       <= acc_nxt;
      held_r      <= held_nxt;
      first_r     <= first_nxt;
      first_vld_r <= first_vld_nxt;
      next_r      <= next_nxt;
      err_r       <= err_nxt;
      last_pend_r <= last_pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    a_r    <= a_nxt;
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  bgen_l2pd_ram #(
    .WIDTH(1),
    .DEPTH(MAX_SAMPLES)
  ) u_miss_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(in_data_byte[MISSING_BIT]),
    .re   (mem_re),
    .raddr(next_r[AW-1:0]),
    .rdata(mem_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_r.kind;
  assign out_sample_index = out_r.index;
  assign out_prob_hom     = out_r.hom;
  assign out_prob_het     = out_r.het;
  assign out_is_missing   = out_r.miss;
  assign out_dosage_fx    = out_r.dosage;
  assign out_status_code  = out_r.status;
  assign out_depth_bits   = out_r.depth;
  assign out_run_last     = out_r.last;

  // a status transaction always closes the run
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind |-> out_run_last && out_sample_index == 16'd0)
    else $error("status result without run_last");

  // bit reservoir never holds a full value on top of a new byte beyond 23 bits
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r < 5'd24)
    else $error("bit reservoir overflow");

  // dosage never exceeds two
  a_dosage_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> out_dosage_fx <= 18'd131072)
    else $error("dosage out of range");

  // the status transaction leaves the variant state cleared
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STAT2 && out_free |=> pos_r == '0 && next_r == '0 && err_r == '0)
    else $error("variant state not cleared");

endmodule
